### rtl/gtdm_pkg.sv
// Shared types, constants and helper functions of the gamepad tank-drive mixer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gtdm_pkg;

    localparam int AXIS_W      = 11;
    localparam int LEVEL_W     = 10;
    localparam int CFG_W       = 9;
    localparam int CFG_ADDR_W  = 1;
    localparam int DUTY_W      = 13;
    localparam int PULSE_W     = 10;
    localparam int BTN_W       = 5;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LEVEL = 1'b1;

    localparam logic [CFG_W-1:0] DEADBAND_RST  = 9'd30;
    localparam logic [CFG_W-1:0] MIN_LEVEL_RST = 9'd60;

    localparam logic [2:0] BTN_Y  = 3'd0;
    localparam logic [2:0] BTN_A  = 3'd1;
    localparam logic [2:0] BTN_B  = 3'd2;
    localparam logic [2:0] BTN_R1 = 3'd3;
    localparam logic [2:0] BTN_L1 = 3'd4;

    localparam logic signed [11:0] AXIS_LIMIT = 12'sd510;
    localparam logic [10:0]        POWER_DEN  = 11'd2046;

    localparam logic [PULSE_W-1:0] ESC_BASE       = 10'd608;
    localparam logic [PULSE_W-1:0] ESC_PULSE_MAX  = 10'd788;
    localparam logic [20:0]        ESC_OFFSET     = 21'd1256244;
    localparam logic [9:0]         ESC_SLOPE      = 10'd573;
    localparam logic [15:0]        TENTH_RECIP    = 16'd52429;

    typedef enum logic [2:0] {
        WPN_OFF = 3'b001,
        WPN_FWD = 3'b010,
        WPN_REV = 3'b100
    } weapon_mode_t;

    typedef struct packed {
        logic load_mid;
        logic load_out;
    } pipe_ctrl_t;

    function automatic logic signed [9:0] clamp_axis(input logic signed [11:0] x);
        logic signed [9:0] y;
        if (x > AXIS_LIMIT)
        begin
            y = 10'sd510;
        end
        else if (x < -AXIS_LIMIT)
        begin
            y = -10'sd510;
        end
        else
        begin
            y = x[9:0];
        end
        return y;
    endfunction

    function automatic logic [8:0] axis_mag(input logic signed [9:0] x);
        logic signed [9:0] neg;
        neg = -x;
        return x[9] ? neg[8:0] : x[8:0];
    endfunction

endpackage

`default_nettype wire

### rtl/gtdm_buttons.sv
// Button edge detection, weapon mode and flip flag of the tank-drive mixer.
// Depends on gtdm_pkg.
`default_nettype none

module gtdm_buttons
    import gtdm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [BTN_W-1:0] buttons,
    output weapon_mode_t          mode_next,
    output logic                  flip_next
);

    logic [BTN_W-1:0] prev_reg;
    weapon_mode_t     mode_reg;
    logic             flip_reg;
    logic [BTN_W-1:0] rise;

    // Later edges take priority: Y, then A, then B.
    always_comb
    begin
        rise      = buttons & ~prev_reg;
        mode_next = mode_reg;
        if (rise[BTN_Y])
        begin
            mode_next = WPN_FWD;
        end
        if (rise[BTN_A])
        begin
            mode_next = WPN_REV;
        end
        if (rise[BTN_B])
        begin
            mode_next = WPN_OFF;
        end
        if (rise[BTN_R1])
        begin
            flip_next = 1'b0;
        end
        else if (rise[BTN_L1])
        begin
            flip_next = 1'b1;
        end
        else
        begin
            flip_next = flip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            mode_reg <= WPN_OFF;
            flip_reg <= 1'b0;
        end
        else if (accept)
        begin
            prev_reg <= buttons;
            mode_reg <= mode_next;
            flip_reg <= flip_next;
        end
    end

    a_r1_clears_flip: assert property (@(posedge clk) disable iff (!rst_n)
        accept && buttons[BTN_R1] && !prev_reg[BTN_R1] |=> !flip_reg)
        else $error("R1 rising edge did not clear the flip flag");

    a_b_stops_weapon: assert property (@(posedge clk) disable iff (!rst_n)
        accept && buttons[BTN_B] && !prev_reg[BTN_B] |=> mode_reg == WPN_OFF)
        else $error("B rising edge did not turn the weapon off");

    a_prev_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> prev_reg == $past(buttons))
        else $error("Previous button levels not captured on transfer");

endmodule

`default_nettype wire

### rtl/gtdm_drive_path.sv
// Motor mixing path: clamping, dead band, sum and difference, power scaling
// and duty generation over a product register and a result register. Depends on gtdm_pkg.
`default_nettype none

module gtdm_drive_path
    import gtdm_pkg::*;
(
    input  wire logic                      clk,
    input  wire pipe_ctrl_t                ctrl,
    input  wire logic signed [AXIS_W-1:0]  turn_axis,
    input  wire logic signed [AXIS_W-1:0]  drive_axis,
    input  wire logic        [LEVEL_W-1:0] throttle_level,
    input  wire logic                      flip,
    input  wire logic        [CFG_W-1:0]   stick_deadband,
    input  wire logic        [CFG_W-1:0]   motor_min_level,
    output logic                           left_dir,
    output logic             [DUTY_W-1:0]  left_duty,
    output logic                           right_dir,
    output logic             [DUTY_W-1:0]  right_duty
);

    // Exact floor(p / 2046): halve, then divide by 1023 using 1023 * 1025 = 2^20 - 1
    // and one correction step.
    function automatic logic [8:0] div_power(input logic [19:0] p);
        logic [18:0] x;
        logic [29:0] t;
        logic [9:0]  q0;
        logic [19:0] r;
        logic [9:0]  q;
        x  = p[19:1];
        t  = {x, 10'b0} + 30'(x);
        q0 = t[29:20];
        r  = 20'(x) - ({q0, 10'b0} - 20'(q0));
        q  = (r >= 20'd1023) ? q0 + 10'd1 : q0;
        return q[8:0];
    endfunction

    logic signed [9:0]  turn_c, drive_c, drive_f, turn_d, drive_d;
    logic signed [10:0] sum_w, diff_w;
    logic signed [9:0]  s_c, d_c;
    logic        [10:0] factor;
    logic        [19:0] ps_next, pd_next;
    logic        [19:0] ps_reg, pd_reg;
    logic               s_neg_reg, d_pos_reg;
    logic        [8:0]  q_s, q_d;
    logic               left_dir_next, right_dir_next;
    logic [DUTY_W-1:0]  left_duty_next, right_duty_next;

    always_comb
    begin
        turn_c  = clamp_axis({turn_axis[AXIS_W-1], turn_axis});
        drive_c = clamp_axis({drive_axis[AXIS_W-1], drive_axis});
        drive_f = flip ? -drive_c : drive_c;
        drive_d = (axis_mag(drive_f) < stick_deadband) ? 10'sd0 : drive_f;
        turn_d  = (axis_mag(turn_c) < stick_deadband) ? 10'sd0 : turn_c;
        sum_w   = 11'(drive_d) + 11'(turn_d);
        diff_w  = 11'(drive_d) - 11'(turn_d);
        s_c     = clamp_axis({sum_w[10], sum_w});
        d_c     = clamp_axis({diff_w[10], diff_w});
        factor  = POWER_DEN - {1'b0, throttle_level};
        ps_next = 20'(axis_mag(s_c)) * 20'(factor);
        pd_next = 20'(axis_mag(d_c)) * 20'(factor);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mid)
        begin
            ps_reg    <= ps_next;
            pd_reg    <= pd_next;
            s_neg_reg <= s_c[9];
            d_pos_reg <= !d_c[9] && (d_c != 10'sd0);
        end
    end

    // The first motor takes the negated sum, so its direction follows a negative sum.
    always_comb
    begin
        q_s             = div_power(ps_reg);
        q_d             = div_power(pd_reg);
        left_dir_next   = s_neg_reg && (q_s != 9'd0);
        right_dir_next  = d_pos_reg && (q_d != 9'd0);
        left_duty_next  = (q_s > motor_min_level) ? {q_s, 4'b0} : '0;
        right_duty_next = (q_d > motor_min_level) ? {q_d, 4'b0} : '0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            left_dir   <= left_dir_next;
            left_duty  <= left_duty_next;
            right_dir  <= right_dir_next;
            right_duty <= right_duty_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gtdm_esc_path.sv
// Weapon ESC pulse path: brake slope and offset, then an exact division by 10230
// built from a divide by 1023 and a divide by ten. Depends on gtdm_pkg.
`default_nettype none

module gtdm_esc_path
    import gtdm_pkg::*;
(
    input  wire logic                clk,
    input  wire pipe_ctrl_t          ctrl,
    input  wire logic [LEVEL_W-1:0]  brake_level,
    input  wire weapon_mode_t        mode,
    output logic      [PULSE_W-1:0]  esc_pulse
);

    logic [19:0] slope;
    logic [20:0] num_next;
    logic [20:0] num_reg;
    logic [30:0] t;
    logic [10:0] q0;
    logic [21:0] r;
    logic [10:0] q1023;
    logic [26:0] tenth;
    logic [PULSE_W-1:0] pulse_next;

    always_comb
    begin
        slope = 20'(ESC_SLOPE) * 20'(brake_level);
        case (mode)
            WPN_FWD: num_next = ESC_OFFSET + 21'(slope);
            WPN_REV: num_next = ESC_OFFSET - 21'(slope);
            default: num_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mid)
        begin
            num_reg <= num_next;
        end
    end

    always_comb
    begin
        t          = {num_reg, 10'b0} + 31'(num_reg);
        q0         = t[30:20];
        r          = 22'(num_reg) - ({q0, 10'b0} - 22'(q0));
        q1023      = (r >= 22'd1023) ? q0 + 11'd1 : q0;
        tenth      = 27'(q1023) * 27'(TENTH_RECIP);
        pulse_next = ESC_BASE + 10'(tenth[26:19]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            esc_pulse <= pulse_next;
        end
    end

endmodule

`default_nettype wire

### rtl/gamepad_tank_drive_mixer_core.sv
// Gamepad tank-drive mixer, top level: stream ports, configuration registers,
// input register and pipeline control. Depends on gtdm_pkg, gtdm_buttons,
// gtdm_drive_path and gtdm_esc_path.
//
// Each gamepad report taken in a transfer on the slave side gives exactly one
// result on the master side via the input, product and result registers.
// The block takes one report in every cycle while the output is not stalled:
// the input register, the product register of the mixing and ESC paths and
// the result register form a three-stage pipeline with per-stage valid bits,
// so a stalled result holds only the stages behind it. Button edges, weapon
// mode and flip flag are updated at the input transfer, in report order. The
// user must write the dead band and minimum motor level registers through the
// configuration port while no report is in flight (not enforced by the block).
`default_nettype none

module gamepad_tank_drive_mixer_core
    import gtdm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // turn_axis[10:0], drive_axis[21:11], throttle_level[31:22],
    // brake_level[41:32], btn_y[42], btn_a[43], btn_b[44], btn_r1[45],
    // btn_l1[46], zero[47]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // left_dir[0], left_duty[13:1], right_dir[14], right_duty[27:15],
    // esc_pulse[37:28], zero[39:38]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    logic [CFG_W-1:0]          deadband_reg;
    logic [CFG_W-1:0]          min_level_reg;

    logic                      v_in_reg, v_in_next;
    logic                      v_mid_reg, v_mid_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      load_in;
    pipe_ctrl_t                ctrl;

    logic signed [AXIS_W-1:0]  turn_reg;
    logic signed [AXIS_W-1:0]  drive_reg;
    logic [LEVEL_W-1:0]        throttle_reg;
    logic [LEVEL_W-1:0]        brake_reg;
    weapon_mode_t              mode_in_reg;
    logic                      flip_in_reg;

    weapon_mode_t              mode_next;
    logic                      flip_next;

    logic                      left_dir, right_dir;
    logic [DUTY_W-1:0]         left_duty, right_duty;
    logic [PULSE_W-1:0]        esc_pulse;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            min_level_reg <= MIN_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DEADBAND:  deadband_reg  <= cfg_wdata;
                REG_MIN_LEVEL: min_level_reg <= cfg_wdata;
                default:       deadband_reg  <= deadband_reg;
            endcase
        end
    end

    always_comb
    begin
        ctrl.load_out  = v_mid_reg && (!out_valid_reg || m_axis_tready);
        ctrl.load_mid  = v_in_reg && (!v_mid_reg || ctrl.load_out);
        s_axis_tready  = !v_in_reg || ctrl.load_mid;
        load_in        = s_axis_tvalid && s_axis_tready;
        v_in_next      = load_in ? 1'b1 : (ctrl.load_mid ? 1'b0 : v_in_reg);
        v_mid_next     = ctrl.load_mid ? 1'b1 : (ctrl.load_out ? 1'b0 : v_mid_reg);
        out_valid_next = ctrl.load_out ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg      <= 1'b0;
            v_mid_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v_in_reg      <= v_in_next;
            v_mid_reg     <= v_mid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    gtdm_buttons u_buttons (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (load_in),
        .buttons   (s_axis_tdata[46:42]),
        .mode_next (mode_next),
        .flip_next (flip_next)
    );

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            turn_reg     <= s_axis_tdata[10:0];
            drive_reg    <= s_axis_tdata[21:11];
            throttle_reg <= s_axis_tdata[31:22];
            brake_reg    <= s_axis_tdata[41:32];
            mode_in_reg  <= mode_next;
            flip_in_reg  <= flip_next;
        end
    end

    gtdm_drive_path u_drive (
        .clk             (clk),
        .ctrl            (ctrl),
        .turn_axis       (turn_reg),
        .drive_axis      (drive_reg),
        .throttle_level  (throttle_reg),
        .flip            (flip_in_reg),
        .stick_deadband  (deadband_reg),
        .motor_min_level (min_level_reg),
        .left_dir        (left_dir),
        .left_duty       (left_duty),
        .right_dir       (right_dir),
        .right_duty      (right_duty)
    );

    gtdm_esc_path u_esc (
        .clk         (clk),
        .ctrl        (ctrl),
        .brake_level (brake_reg),
        .mode        (mode_in_reg),
        .esc_pulse   (esc_pulse)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, esc_pulse, right_duty, right_dir, left_duty, left_dir};

    a_mid_held: assert property (@(posedge clk) disable iff (!rst_n)
        v_mid_reg && out_valid_reg && !m_axis_tready |=> v_mid_reg)
        else $error("Pipeline stage dropped while the result was stalled");

    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        v_in_reg && !s_axis_tready |=> v_in_reg)
        else $error("Input stage dropped while the pipeline was stalled");

    a_esc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (esc_pulse >= ESC_BASE) && (esc_pulse <= ESC_PULSE_MAX))
        else $error("ESC pulse outside its range");

    a_duty_grain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (left_duty[3:0] == 4'd0) && (right_duty[3:0] == 4'd0))
        else $error("Motor duty not a multiple of sixteen");

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for gamepad_tank_drive_mixer_core: directed and random gamepad reports
// are checked against an in-bench predictor of the stick mixing, button edges and ESC pulse.
// Depends on gtdm_pkg and the block's RTL only.
`default_nettype none

module testbench
    import gtdm_pkg::*;
();

    localparam int AXIS_MAX     = 510;
    localparam int DUTY_FACTOR  = 16;
    localparam int SCALE_DEN    = 2046;
    localparam int PULSE_IDLE   = 608;
    localparam int PULSE_OFFSET = 1256244;
    localparam int PULSE_SLOPE  = 573;
    localparam int PULSE_DEN    = 10230;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASE_COUNT  = 8;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [4:0] MASK_Y  = 5'b1 << BTN_Y;
    localparam logic [4:0] MASK_A  = 5'b1 << BTN_A;
    localparam logic [4:0] MASK_B  = 5'b1 << BTN_B;
    localparam logic [4:0] MASK_R1 = 5'b1 << BTN_R1;
    localparam logic [4:0] MASK_L1 = 5'b1 << BTN_L1;

    typedef struct packed {
        logic signed [AXIS_W-1:0] turn;
        logic signed [AXIS_W-1:0] drive;
        logic [LEVEL_W-1:0]       throttle;
        logic [LEVEL_W-1:0]       brake;
        logic [BTN_W-1:0]         buttons;
    } report_t;

    typedef struct packed {
        logic               left_dir;
        logic [DUTY_W-1:0]  left_duty;
        logic               right_dir;
        logic [DUTY_W-1:0]  right_duty;
        logic [PULSE_W-1:0] esc_pulse;
        logic [1:0]         pad;
    } motor_cmd_t;

    typedef struct {
        report_t    rep;
        bit         typed;
        motor_cmd_t want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]       cfg_wdata;

    logic [CFG_W-1:0] deadband;
    logic [CFG_W-1:0] min_level;
    logic [BTN_W-1:0] prev_buttons;
    weapon_mode_t     weapon;
    logic             flipped;
    logic [BTN_W-1:0] held_buttons;

    motor_cmd_t pending_cmds[$];
    row_t       directed_rows[$];
    int         error_count;
    int         accepted_count;
    int         checked_count;
    int         settings_count;
    bit         steady;
    bit         hold_done;

    gamepad_tank_drive_mixer_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #(12 * 400000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int clamp_axis_val(input int x);
        if (x > AXIS_MAX)
        begin
            return AXIS_MAX;
        end
        if (x < -AXIS_MAX)
        begin
            return -AXIS_MAX;
        end
        return x;
    endfunction

    function automatic int apply_deadband(input int x);
        int m;
        m = (x < 0) ? -x : x;
        return (m < int'(deadband)) ? 0 : x;
    endfunction

    function automatic logic [13:0] motor_word(input int p);
        int          m;
        logic [12:0] duty;
        m = (p < 0) ? -p : p;
        duty = (m > int'(min_level)) ? 13'(m * DUTY_FACTOR) : 13'd0;
        return {duty, (p > 0) ? 1'b1 : 1'b0};
    endfunction

    // Updates the button history, weapon mode and flip flag, then returns the command.
    function automatic motor_cmd_t mix_report(input report_t r);
        logic [BTN_W-1:0] rise;
        logic [13:0]      w1;
        logic [13:0]      w2;
        int               turn;
        int               drive;
        int               thr;
        int               brk;
        int               num;
        int               s;
        int               d;
        motor_cmd_t       o;
        rise = r.buttons & ~prev_buttons;
        if (rise[BTN_Y])
        begin
            weapon = WPN_FWD;
        end
        if (rise[BTN_A])
        begin
            weapon = WPN_REV;
        end
        if (rise[BTN_B])
        begin
            weapon = WPN_OFF;
        end
        if (rise[BTN_R1])
        begin
            flipped = 1'b0;
        end
        else if (rise[BTN_L1])
        begin
            flipped = 1'b1;
        end
        prev_buttons = r.buttons;

        thr = r.throttle;
        brk = r.brake;
        case (weapon)
            WPN_FWD: num = PULSE_OFFSET + PULSE_SLOPE * brk;
            WPN_REV: num = PULSE_OFFSET - PULSE_SLOPE * brk;
            default: num = 0;
        endcase

        turn = clamp_axis_val(r.turn);
        drive = clamp_axis_val(r.drive);
        if (flipped)
        begin
            drive = -drive;
        end
        drive = apply_deadband(drive);
        turn = apply_deadband(turn);
        s = clamp_axis_val(drive + turn);
        d = clamp_axis_val(drive - turn);
        w1 = motor_word(-((s * (SCALE_DEN - thr)) / SCALE_DEN));
        w2 = motor_word((d * (SCALE_DEN - thr)) / SCALE_DEN);

        o.left_dir = w1[0];
        o.left_duty = w1[13:1];
        o.right_dir = w2[0];
        o.right_duty = w2[13:1];
        o.esc_pulse = 10'(PULSE_IDLE + num / PULSE_DEN);
        o.pad = 2'b00;
        return o;
    endfunction

    function automatic row_t make_row(input int turn, input int drive, input int thr,
                                      input int brk, input logic [4:0] btn, input bit typed,
                                      input bit ld, input int lduty, input bit rd,
                                      input int rduty, input int esc);
        row_t row;
        row.rep.turn = 11'(turn);
        row.rep.drive = 11'(drive);
        row.rep.throttle = 10'(thr);
        row.rep.brake = 10'(brk);
        row.rep.buttons = btn;
        row.typed = typed;
        row.want.left_dir = ld;
        row.want.left_duty = 13'(lduty);
        row.want.right_dir = rd;
        row.want.right_duty = 13'(rduty);
        row.want.esc_pulse = 10'(esc);
        row.want.pad = 2'b00;
        return row;
    endfunction

    function automatic int random_axis();
        int pick;
        int m;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            return int'($signed(11'($urandom)));
        end
        if (pick < 7)
        begin
            return $urandom_range(0, 1020) - AXIS_MAX;
        end
        if (pick < 9)
        begin
            m = int'(deadband) + $urandom_range(0, 4) - 2;
            return $urandom_range(0, 1) ? m : -m;
        end
        case ($urandom_range(0, 6))
            0: return -1024;
            1: return 1023;
            2: return 512;
            3: return -511;
            4: return AXIS_MAX;
            5: return -AXIS_MAX;
            default: return 0;
        endcase
    endfunction

    function automatic report_t random_report();
        report_t r;
        int      i;
        for (i = 0; i < BTN_W; i++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                held_buttons[i] = ~held_buttons[i];
            end
        end
        r.turn = 11'(random_axis());
        r.drive = 11'(random_axis());
        r.throttle = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 10'h3FF : 10'h000)
                                                 : 10'($urandom);
        r.brake = 10'($urandom);
        r.buttons = held_buttons;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_report(input report_t r, input bit typed, input motor_cmd_t want);
        motor_cmd_t predicted;
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, r.buttons, r.brake, r.throttle, r.drive, r.turn};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predicted = mix_report(r);
        pending_cmds.push_back(typed ? want : predicted);
        accepted_count++;
    endtask

    task automatic drain_and_configure(input int db, input int lvl);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_DEADBAND;
        cfg_wdata <= 9'(db);
        @(negedge clk);
        cfg_addr <= REG_MIN_LEVEL;
        cfg_wdata <= 9'(lvl);
        @(negedge clk);
        cfg_we <= 1'b0;
        deadband = 9'(db);
        min_level = 9'(lvl);
        settings_count++;
    endtask

    // Receiver side: random back-pressure, plus one long hold-off to fill the pipeline.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_count >= 150)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge clk)
    begin : check_outputs
        motor_cmd_t got;
        motor_cmd_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.left_dir = m_axis_tdata[0];
            got.left_duty = m_axis_tdata[13:1];
            got.right_dir = m_axis_tdata[14];
            got.right_duty = m_axis_tdata[27:15];
            got.esc_pulse = m_axis_tdata[37:28];
            got.pad = m_axis_tdata[39:38];
            if (pending_cmds.size() == 0)
            begin
                report_mismatch("result with nothing outstanding, tdata", int'(m_axis_tdata), 0);
            end
            else
            begin
                want = pending_cmds.pop_front();
                checked_count++;
                if (got.left_dir !== want.left_dir)
                begin
                    report_mismatch("left_dir", got.left_dir, want.left_dir);
                end
                if (got.left_duty !== want.left_duty)
                begin
                    report_mismatch("left_duty", got.left_duty, want.left_duty);
                end
                if (got.right_dir !== want.right_dir)
                begin
                    report_mismatch("right_dir", got.right_dir, want.right_dir);
                end
                if (got.right_duty !== want.right_duty)
                begin
                    report_mismatch("right_duty", got.right_duty, want.right_duty);
                end
                if (got.esc_pulse !== want.esc_pulse)
                begin
                    report_mismatch("esc_pulse", got.esc_pulse, want.esc_pulse);
                end
                if (got.pad !== want.pad)
                begin
                    report_mismatch("tdata padding", got.pad, want.pad);
                end
            end
        end
    end

    initial
    begin
        int         phase;
        int         n;
        motor_cmd_t none;
        row_t       row;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = REG_DEADBAND;
        cfg_wdata = '0;
        error_count = 0;
        accepted_count = 0;
        checked_count = 0;
        settings_count = 1;
        steady = 1'b0;
        hold_done = 1'b0;
        held_buttons = '0;
        none = '0;
        deadband = DEADBAND_RST;
        min_level = MIN_LEVEL_RST;
        prev_buttons = '0;
        weapon = WPN_OFF;
        flipped = 1'b0;

        // Sticks and weapon mode from reset, axis clamping, dead band and minimum level edges,
        // button edge priority, then flip handling.
        directed_rows.push_back(make_row(0, 0, 0, 0, 5'b0, 1, 0, 0, 0, 0, 608));
        directed_rows.push_back(make_row(0, 512, 0, 0, 5'b0, 1, 0, 8160, 1, 8160, 608));
        directed_rows.push_back(make_row(0, -511, 0, 0, 5'b0, 1, 1, 8160, 0, 8160, 608));
        directed_rows.push_back(make_row(512, 0, 0, 0, 5'b0, 1, 0, 8160, 0, 8160, 608));
        directed_rows.push_back(make_row(-511, 0, 0, 0, 5'b0, 1, 1, 8160, 1, 8160, 608));
        directed_rows.push_back(make_row(-1024, 1023, 0, 0, 5'b0, 1, 0, 0, 1, 8160, 608));
        directed_rows.push_back(make_row(510, 510, 1023, 0, 5'b0, 1, 0, 4080, 0, 0, 608));
        directed_rows.push_back(make_row(0, 29, 0, 0, 5'b0, 1, 0, 0, 0, 0, 608));
        directed_rows.push_back(make_row(0, 30, 0, 0, 5'b0, 1, 0, 0, 1, 0, 608));
        directed_rows.push_back(make_row(-29, 61, 0, 0, 5'b0, 1, 0, 976, 1, 976, 608));
        directed_rows.push_back(make_row(0, 0, 0, 1023, MASK_Y, 1, 0, 0, 0, 0, 788));
        directed_rows.push_back(make_row(0, 0, 0, 1023, MASK_Y | MASK_A, 1, 0, 0, 0, 0, 673));
        directed_rows.push_back(make_row(0, 0, 0, 0, 5'b0, 1, 0, 0, 0, 0, 730));
        directed_rows.push_back(make_row(0, 0, 0, 700, MASK_B, 1, 0, 0, 0, 0, 608));
        directed_rows.push_back(make_row(0, 0, 0, 700, 5'b0, 1, 0, 0, 0, 0, 608));
        directed_rows.push_back(make_row(0, 0, 0, 512, MASK_Y | MASK_A, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, 0, 512, 5'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(0, 0, 0, 1023, MASK_Y | MASK_A | MASK_B, 1,
                                         0, 0, 0, 0, 608));
        directed_rows.push_back(make_row(0, 300, 0, 0, MASK_L1, 1, 1, 4800, 0, 4800, 608));
        directed_rows.push_back(make_row(0, 300, 0, 0, 5'b0, 1, 1, 4800, 0, 4800, 608));
        directed_rows.push_back(make_row(0, 300, 0, 0, MASK_R1 | MASK_L1, 1,
                                         0, 4800, 1, 4800, 608));
        directed_rows.push_back(make_row(150, -200, 700, 300, MASK_L1 | MASK_Y, 0,
                                         0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(333, -77, 1000, 0, 5'b0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(-400, 451, 1, 1, MASK_R1, 0, 0, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            send_report(row.rep, row.typed, row.want);
        end
        held_buttons = prev_buttons;

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: drain_and_configure(0, 0);
                1: drain_and_configure(511, 511);
                2: drain_and_configure(510, 510);
                3: drain_and_configure(1, 509);
                default: drain_and_configure($urandom_range(0, 120), $urandom_range(0, 300));
            endcase
            steady = (phase == 4);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_report(random_report(), 1'b0, none);
            end
            steady = 1'b0;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d reports (directed and random) under %0d register settings,",
                 accepted_count, settings_count);
        $display("%0d motor and weapon commands checked, one long output stall included.",
                 checked_count);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
rtl/gtdm_pkg.sv
rtl/gtdm_buttons.sv
rtl/gtdm_drive_path.sv
rtl/gtdm_esc_path.sv
rtl/gamepad_tank_drive_mixer_core.sv
tb/testbench.sv
